// File: rtl/drt_pkg.sv
// ----------------------------------------------------------------------------
// drt_pkg: shared definitions for the delimited record tokenizer
// Kind and status codes, register indexes, reset values and character codes.
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam int POSITION_BITS_DEF = 32;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_DELIMITER_CHAR   = 2'd0,
    CFG_CRLF_MODE        = 2'd1,
    CFG_EXPECTED_COLUMNS = 2'd2,
    CFG_HEADER_ROWS      = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    KIND_STATUS     = 3'd0,
    KIND_RECORD     = 3'd1,
    KIND_HEADER     = 3'd2,
    KIND_FIELD      = 3'd3,
    KIND_DELIMITER  = 3'd4,
    KIND_TERMINATOR = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_TERM     = 2'd1,
    ST_COL_MISMATCH = 2'd2,
    ST_UNTERMINATED = 2'd3
  } status_t;

  localparam logic [6:0]  DELIMITER_RESET = 7'd44;
  localparam logic [15:0] COLUMNS_RESET   = 16'd1;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  localparam int COL_BITS = 17;

endpackage

// File: rtl/drt_byte_if.sv
// ----------------------------------------------------------------------------
// drt_byte_if: text byte channel
// One byte of the span with its position and an end-of-span mark.
// ----------------------------------------------------------------------------
interface drt_byte_if #(
  parameter int POSITION_BITS = 32
);
  logic                     valid;
  logic                     ready;
  logic [7:0]               data_byte;
  logic [POSITION_BITS-1:0] byte_position;
  logic                     span_last;

  modport source (output valid, output data_byte, output byte_position,
                  output span_last, input ready);
  modport sink   (input valid, input data_byte, input byte_position,
                  input span_last, output ready);
endinterface

// File: rtl/drt_token_if.sv
// ----------------------------------------------------------------------------
// drt_token_if: token channel
// One reported span or status item.
// ----------------------------------------------------------------------------
interface drt_token_if #(
  parameter int POSITION_BITS = 32
);
  logic                     valid;
  logic                     ready;
  logic [2:0]               kind_code;
  logic [POSITION_BITS-1:0] span_start;
  logic [POSITION_BITS-1:0] span_end;
  logic [1:0]               status;
  logic                     run_last;
  logic                     span_done;

  modport source (output valid, output kind_code, output span_start,
                  output span_end, output status, output run_last,
                  output span_done, input ready);
  modport sink   (input valid, input kind_code, input span_start,
                  input span_end, input status, input run_last,
                  input span_done, output ready);
endinterface

// File: rtl/drt_cfg_if.sv
// ----------------------------------------------------------------------------
// drt_cfg_if: configuration write channel
// Register index and write data.
// ----------------------------------------------------------------------------
interface drt_cfg_if
  import drt_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] reg_index;
  logic [CFG_DATA_BITS-1:0]  wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: rtl/delimited_record_tokenizer.sv
// ----------------------------------------------------------------------------
// delimited_record_tokenizer: delimited text field splitter
// Splits a byte stream into field, delimiter, record, header and terminator spans,
// checking terminators and column counts per line.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  bytes    in   data_byte, byte_position, span_last
//  tokens   out  kind_code, span_start, span_end, status, run_last, span_done
//  cfg      in   reg_index, wr_data (always ready)
//
// A byte is taken on a valid-ready handshake; the tokenizer state updates at that edge.
// A byte gives zero to three items, driven one per cycle while tokens.ready is high, from a group register.
// A second group slot takes the next byte while the current group drains.
// Throughput: one byte per cycle while each byte yields at most one item and tokens.ready stays high.
// rst is synchronous and restores register defaults and the per-span state, and empties both group slots.
// ----------------------------------------------------------------------------
module delimited_record_tokenizer
  import drt_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  drt_byte_if.sink       bytes,
  drt_token_if.source    tokens,
  drt_cfg_if.sink        cfg
);

  localparam int PW = POSITION_BITS;

  typedef struct packed {
    kind_t         kind;
    logic [PW-1:0] start;
    logic [PW-1:0] stop;
    status_t       status;
  } res_t;

  typedef struct packed {
    res_t [2:0]  res;
    logic [1:0]  last_idx;
    logic        done;
  } grp_t;

  logic [6:0]  delimiter_char;
  logic        crlf_mode;
  logic [15:0] expected_columns;
  logic        header_rows;

  logic [PW-1:0]       line_begin_pos, line_begin_pos_next;
  logic [PW-1:0]       field_begin_pos, field_begin_pos_next;
  logic [COL_BITS-1:0] columns_seen, columns_seen_next;
  logic                previous_was_cr, previous_was_cr_next;
  logic                at_line_begin, at_line_begin_next;
  logic                first_row_pending, first_row_pending_next;
  logic                aborted, aborted_next;

  grp_t       gen;
  logic [2:0] gen_cnt;
  logic       abort_now, end_now;

  logic [PW-1:0]       pos, pos_inc, lb, fb, cend;
  logic [COL_BITS-1:0] cols_inc;
  logic                bad_term;

  grp_t       head, tail;
  logic       head_valid, tail_valid;
  logic [1:0] head_idx;
  logic       head_step, head_done, accept, push;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_char   <= DELIMITER_RESET;
      crlf_mode        <= 1'b0;
      expected_columns <= COLUMNS_RESET;
      header_rows      <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg_index_t'(cfg.reg_index))
        CFG_DELIMITER_CHAR:   delimiter_char   <= cfg.wr_data[6:0];
        CFG_CRLF_MODE:        crlf_mode        <= cfg.wr_data[0];
        CFG_EXPECTED_COLUMNS: expected_columns <= cfg.wr_data;
        CFG_HEADER_ROWS:      header_rows      <= cfg.wr_data[0];
      endcase
    end
  end

  // per-byte decode
  assign pos      = bytes.byte_position;
  assign pos_inc  = pos + PW'(1);
  assign lb       = at_line_begin ? pos : line_begin_pos;
  assign fb       = at_line_begin ? pos : field_begin_pos;
  assign cend     = crlf_mode ? pos - PW'(1) : pos;
  assign cols_inc = (&columns_seen) ? columns_seen : columns_seen + COL_BITS'(1);
  assign bad_term = crlf_mode ? !previous_was_cr : previous_was_cr;

  always_comb begin
    gen                    = '0;
    gen_cnt                = 3'd0;
    abort_now              = 1'b0;
    end_now                = 1'b0;
    line_begin_pos_next    = lb;
    field_begin_pos_next   = fb;
    columns_seen_next      = columns_seen;
    previous_was_cr_next   = previous_was_cr;
    at_line_begin_next     = 1'b0;
    first_row_pending_next = first_row_pending;
    aborted_next           = aborted;

    if (aborted) begin
      line_begin_pos_next  = line_begin_pos;
      field_begin_pos_next = field_begin_pos;
      at_line_begin_next   = at_line_begin;
    end else if (bytes.data_byte == CHAR_LF) begin
      if (bad_term) begin
        gen.res[gen_cnt[1:0]] = '{KIND_STATUS, '0, '0, ST_BAD_TERM};
        gen_cnt   = gen_cnt + 3'd1;
        abort_now = 1'b1;
      end else begin
        if (cend > fb) begin
          gen.res[gen_cnt[1:0]] = '{KIND_FIELD, fb, cend, ST_OK};
          gen_cnt = gen_cnt + 3'd1;
        end
        columns_seen_next = cols_inc;
        if (cend > lb) begin
          gen.res[gen_cnt[1:0]] = '{(first_row_pending && header_rows) ?
                                    KIND_HEADER : KIND_RECORD, lb, cend, ST_OK};
          gen_cnt = gen_cnt + 3'd1;
        end
        if (cols_inc != {1'b0, expected_columns}) begin
          gen.res[gen_cnt[1:0]] = '{KIND_STATUS, '0, '0, ST_COL_MISMATCH};
          gen_cnt   = gen_cnt + 3'd1;
          abort_now = 1'b1;
        end else begin
          gen.res[gen_cnt[1:0]] = '{KIND_TERMINATOR, cend, pos_inc, ST_OK};
          gen_cnt                = gen_cnt + 3'd1;
          columns_seen_next      = '0;
          previous_was_cr_next   = 1'b0;
          at_line_begin_next     = 1'b1;
          first_row_pending_next = 1'b0;
          end_now                = bytes.span_last;
        end
      end
    end else if (bytes.span_last) begin
      gen.res[gen_cnt[1:0]] = '{KIND_STATUS, '0, '0, ST_UNTERMINATED};
      gen_cnt   = gen_cnt + 3'd1;
      abort_now = 1'b1;
    end else begin
      if (bytes.data_byte == {1'b0, delimiter_char}) begin
        if (pos > fb) begin
          gen.res[gen_cnt[1:0]] = '{KIND_FIELD, fb, pos, ST_OK};
          gen_cnt = gen_cnt + 3'd1;
        end
        columns_seen_next     = cols_inc;
        gen.res[gen_cnt[1:0]] = '{KIND_DELIMITER, pos, pos_inc, ST_OK};
        gen_cnt               = gen_cnt + 3'd1;
        field_begin_pos_next  = pos_inc;
      end
      previous_was_cr_next = (bytes.data_byte == CHAR_CR);
    end

    if (abort_now) aborted_next = 1'b1;

    gen.last_idx = gen_cnt[1:0] - 2'd1;
    gen.done     = abort_now || end_now;

    if (end_now || (bytes.span_last && (aborted || abort_now))) begin
      columns_seen_next      = '0;
      previous_was_cr_next   = 1'b0;
      at_line_begin_next     = 1'b1;
      first_row_pending_next = 1'b1;
      aborted_next           = 1'b0;
    end
  end

  assign bytes.ready = !tail_valid;
  assign accept      = bytes.valid && bytes.ready;
  assign push        = accept && (gen_cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_begin_pos    <= '0;
      field_begin_pos   <= '0;
      columns_seen      <= '0;
      previous_was_cr   <= 1'b0;
      at_line_begin     <= 1'b1;
      first_row_pending <= 1'b1;
      aborted           <= 1'b0;
    end else if (accept) begin
      line_begin_pos    <= line_begin_pos_next;
      field_begin_pos   <= field_begin_pos_next;
      columns_seen      <= columns_seen_next;
      previous_was_cr   <= previous_was_cr_next;
      at_line_begin     <= at_line_begin_next;
      first_row_pending <= first_row_pending_next;
      aborted           <= aborted_next;
    end
  end

  // result groups: head drains one item per cycle while tokens.ready is high, tail holds the next group
  assign head_step = head_valid && tokens.ready;
  assign head_done = head_step && (head_idx == head.last_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
      head_idx   <= '0;
    end else if (head_done || !head_valid) begin
      head_idx <= '0;
      if (tail_valid) begin
        head_valid <= 1'b1;
        tail_valid <= 1'b0;
      end else begin
        head_valid <= push;
      end
    end else begin
      if (head_step) head_idx <= head_idx + 2'd1;
      if (push) tail_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_done || !head_valid) begin
      if (tail_valid) head <= tail;
      else if (push) head <= gen;
    end else if (push) begin
      tail <= gen;
    end
  end

  assign tokens.valid      = head_valid;
  assign tokens.kind_code  = head.res[head_idx].kind;
  assign tokens.span_start = head.res[head_idx].start;
  assign tokens.span_end   = head.res[head_idx].stop;
  assign tokens.status     = head.res[head_idx].status;
  assign tokens.run_last   = (head_idx == head.last_idx);
  assign tokens.span_done  = head.done && (head_idx == head.last_idx);

  a_tail_needs_head: assert property (@(posedge clk) disable iff (rst)
    tail_valid |-> head_valid)
    else $error("tail group held with empty head");

  a_idx_in_group: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> head_idx <= head.last_idx)
    else $error("item index beyond group");

  a_span_restart: assert property (@(posedge clk) disable iff (rst)
    accept && bytes.span_last |=> at_line_begin && first_row_pending && !aborted &&
      columns_seen == '0)
    else $error("span state not restored after last byte");

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    tokens.valid && tokens.status != ST_OK |->
      tokens.kind_code == KIND_STATUS && tokens.run_last && tokens.span_done)
    else $error("error item not a closing status item");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    tokens.valid && tokens.span_done |-> tokens.run_last)
    else $error("span done on an inner item");

endmodule
